### sv/lcg_random_with_categorical_pick_assert.svh
// assertion macros for the lcg random block
`ifndef LCG_RANDOM_WITH_CATEGORICAL_PICK_ASSERT_SVH
`define LCG_RANDOM_WITH_CATEGORICAL_PICK_ASSERT_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### sv/lcgp_pkg.sv
package lcgp_pkg;

	localparam int MAX_CHOICES  = 256;
	localparam int CNT_W        = $clog2(MAX_CHOICES);
	localparam int WARMUP_STEPS = 20;
	localparam int WARM_W       = $clog2(WARMUP_STEPS);

	localparam logic [63:0] MULT_RESET = 64'd6364136223846793005;
	localparam logic [63:0] INCR_RESET = 64'd1442695040888963407;
	localparam logic [24:0] SUM_MAX    = 25'h1FFFFFF;

	typedef enum logic [1:0] {
		KIND_SEED   = 2'd0,
		KIND_WORD   = 2'd1,
		KIND_FRAC   = 2'd2,
		KIND_WEIGHT = 2'd3
	} kind_t;

	localparam logic [1:0] RES_WORD  = 2'd0;
	localparam logic [1:0] RES_FRAC  = 2'd1;
	localparam logic [1:0] RES_INDEX = 2'd2;

	localparam logic REG_MULT = 1'b0;
	localparam logic REG_INCR = 1'b1;

	typedef enum logic [1:0] {
		PH_LL  = 2'd0,
		PH_HL  = 2'd1,
		PH_LH  = 2'd2,
		PH_FIN = 2'd3
	} mul_ph_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PH0,
		ST_PH1,
		ST_PH2,
		ST_PH3,
		ST_PICK,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic    item_load;
		logic    step_en;
		mul_ph_t phase;
		logic    pick_en;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  hit;
		logic  out_free;
	} dp_sts_t;

endpackage

### sv/lcgp_ctrl.sv
module lcgp_ctrl
	import lcgp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  kind_t   in_kind,
	input  logic    in_first,
	input  dp_sts_t sts,
	output dp_cmd_t cmd,
	output logic    busy
);

	state_t state_q, state_nx;
	logic [WARM_W-1:0] warm_q;
	logic accept;

	assign accept = (state_q == ST_IDLE) && in_valid;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_kind == KIND_WEIGHT && !in_first)
						state_nx = ST_PICK;
					else
						state_nx = ST_PH0;
				end
			end
			ST_PH0: state_nx = ST_PH1;
			ST_PH1: state_nx = ST_PH2;
			ST_PH2: state_nx = ST_PH3;
			ST_PH3: begin
				case (sts.kind)
					KIND_SEED:   state_nx = (warm_q == '0) ? ST_IDLE : ST_PH0;
					KIND_WEIGHT: state_nx = ST_PICK;
					default:     state_nx = ST_EMIT;
				endcase
			end
			ST_PICK: state_nx = sts.hit ? ST_EMIT : ST_IDLE;
			ST_EMIT: state_nx = sts.out_free ? ST_IDLE : ST_EMIT;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.item_load = accept;
		cmd.step_en   = 1'b0;
		cmd.phase     = PH_LL;
		cmd.pick_en   = 1'b0;
		cmd.out_load  = 1'b0;
		busy          = (state_q != ST_IDLE);
		case (state_q)
			ST_PH0: begin
				cmd.step_en = 1'b1;
				cmd.phase   = PH_LL;
			end
			ST_PH1: begin
				cmd.step_en = 1'b1;
				cmd.phase   = PH_HL;
			end
			ST_PH2: begin
				cmd.step_en = 1'b1;
				cmd.phase   = PH_LH;
			end
			ST_PH3: begin
				cmd.step_en = 1'b1;
				cmd.phase   = PH_FIN;
			end
			ST_PICK: cmd.pick_en  = 1'b1;
			ST_EMIT: cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			warm_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (accept)
				warm_q <= WARM_W'(WARMUP_STEPS - 1);
			else if (state_q == ST_PH3 && sts.kind == KIND_SEED && warm_q != '0)
				warm_q <= warm_q - 1'b1;
		end
	end

endmodule

### sv/lcgp_dp.sv
module lcgp_dp
	import lcgp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic [1:0]  kind,
	input  logic [63:0] seed_value,
	input  logic [24:0] weight,
	input  logic        first_weight,
	input  logic        last_weight,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [31:0] value
);

	logic [63:0] mult_q, incr_q;
	logic [63:0] state_q;
	logic [63:0] prod_q, acc_q;
	logic [31:0] mul_a, mul_b;
	logic [63:0] product;

	kind_t       kind_q;
	logic [24:0] w_q;
	logic        first_q, last_q;

	logic [23:0]      thr_q;
	logic [24:0]      sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic             found_q;
	logic [CNT_W-1:0] idx_q;

	logic [24:0]      base_sum;
	logic [CNT_W-1:0] base_cnt;
	logic             base_found;
	logic [23:0]      thr_eff;
	logic [25:0]      sum_raw;
	logic [24:0]      sum_sat;
	logic             hit;

	logic        out_valid_q;
	logic [1:0]  res_kind_q;
	logic [31:0] value_q;
	logic [1:0]  emit_kind;
	logic [31:0] emit_value;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q <= MULT_RESET;
			incr_q <= INCR_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_MULT)
				mult_q <= cfg_data;
			else
				incr_q <= cfg_data;
		end
	end

	// word latch
	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			kind_q  <= kind_t'(kind);
			w_q     <= weight;
			first_q <= first_weight;
			last_q  <= last_weight;
		end
	end

	// shared 32x32 multiplier, low 64 bits of state*mult+incr built over four phases
	always_comb begin
		case (cmd.phase)
			PH_HL: begin
				mul_a = state_q[63:32];
				mul_b = mult_q[31:0];
			end
			PH_LH: begin
				mul_a = state_q[31:0];
				mul_b = mult_q[63:32];
			end
			default: begin
				mul_a = state_q[31:0];
				mul_b = mult_q[31:0];
			end
		endcase
	end

	assign product = {32'd0, mul_a} * {32'd0, mul_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (cmd.item_load && kind_t'(kind) == KIND_SEED) begin
			state_q <= seed_value;
		end else if (cmd.step_en && cmd.phase == PH_FIN) begin
			state_q <= {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step_en) begin
			prod_q <= product;
			case (cmd.phase)
				PH_HL:   acc_q <= prod_q + incr_q;
				PH_LH:   acc_q[63:32] <= acc_q[63:32] + prod_q[31:0];
				default: ;
			endcase
		end
	end

	// categorical pick
	assign base_sum   = first_q ? '0 : sum_q;
	assign base_cnt   = first_q ? '0 : cnt_q;
	assign base_found = first_q ? 1'b0 : found_q;
	assign thr_eff    = first_q ? state_q[63:40] : thr_q;
	assign sum_raw    = {1'b0, base_sum} + {1'b0, w_q};
	assign sum_sat    = sum_raw[25] ? SUM_MAX : sum_raw[24:0];
	assign hit        = !base_found && ((sum_sat >= {1'b0, thr_eff}) || last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= '0;
			sum_q   <= '0;
			cnt_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.pick_en) begin
			thr_q   <= thr_eff;
			sum_q   <= sum_sat;
			found_q <= base_found | hit;
			if (base_cnt != CNT_W'(MAX_CHOICES - 1))
				cnt_q <= base_cnt + 1'b1;
			else
				cnt_q <= base_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pick_en)
			idx_q <= base_cnt;
	end

	// output register
	always_comb begin
		case (kind_q)
			KIND_WORD: begin
				emit_kind  = RES_WORD;
				emit_value = state_q[63:32];
			end
			KIND_FRAC: begin
				emit_kind  = RES_FRAC;
				emit_value = {8'd0, state_q[63:40]};
			end
			default: begin
				emit_kind  = RES_INDEX;
				emit_value = 32'(idx_q);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_kind_q <= emit_kind;
			value_q    <= emit_value;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = res_kind_q;
	assign value        = value_q;
	assign sts.kind     = kind_q;
	assign sts.hit      = hit;
	assign sts.out_free = !out_valid_q || !out_stall;

endmodule

### sv/lcg_random_with_categorical_pick.sv
// channel  dir  handshake             fields
// in       in   in_valid / in_stall   kind, seed_value, weight, first_weight, last_weight
// out      out  out_valid / out_stall result_kind, value
// cfg      in   cfg_we                cfg_index, cfg_data
//
// one generator step runs through states ST_PH0 to ST_PH3 on a single shared 32x32 multiplier
// word/fraction draw: one generator step, then the result is emitted; seed: 20 generator steps
// weight: a pick, after a generator step when it has the first mark, then an output state when an index is given
// the output register holds a word while out_stall is high; the block waits only to load it
// asynchronous active-low reset restores the default multiplier and increment
`include "lcg_random_with_categorical_pick_assert.svh"

module lcg_random_with_categorical_pick
	import lcgp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [63:0] seed_value,
	input  logic [24:0] weight,
	input  logic        first_weight,
	input  logic        last_weight,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [31:0] value
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    busy;

	lcgp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_kind  (kind_t'(kind)),
		.in_first (first_weight),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	lcgp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.kind         (kind),
		.seed_value   (seed_value),
		.weight       (weight),
		.first_weight (first_weight),
		.last_weight  (last_weight),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.value        (value)
	);

	assign in_stall = busy;

	`ASSERT_NEXT(a_seed_busy, clk, arst_n, in_valid && !in_stall && kind == KIND_SEED, in_stall, "seed not in progress")
	`ASSERT_IMPLY(a_out_from_emit, clk, arst_n, $rose(out_valid), $past(in_stall), "result without work")
	`ASSERT_IMPLY(a_frac_range, clk, arst_n, out_valid && result_kind == RES_FRAC, value[31:24] == 8'd0, "fraction out of range")

endmodule

### sim/lcg_random_with_categorical_pick_tb.sv
`timescale 1ns / 1ps

module lcg_random_with_categorical_pick_tb;
	import lcgp_pkg::*;

	localparam int LIMIT = 1000000;
	localparam int SETTLE = 100;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [1:0]  rk;
		logic [31:0] val;
	} draw_t;

	typedef struct packed {
		kind_t       k;
		logic [63:0] sd;
		logic [24:0] w;
		logic        f;
		logic        l;
		logic        typed;
		logic [1:0]  rk;
		logic [31:0] val;
	} stim_row_t;

	localparam stim_row_t DIRECTED [25] = '{
		'{KIND_WEIGHT, 64'd0, 25'd0, 1'b0, 1'b0, 1'b1, RES_INDEX, 32'd0},
		'{KIND_WEIGHT, 64'd0, 25'h1000000, 1'b0, 1'b0, 1'b0, RES_WORD, 32'd0},
		'{KIND_WEIGHT, 64'd0, 25'd0, 1'b0, 1'b1, 1'b0, RES_WORD, 32'd0},
		'{KIND_WORD, 64'd0, 25'd0, 1'b0, 1'b0, 1'b1, RES_WORD, 32'h14057B7E},
		'{KIND_FRAC, 64'd0, 25'd0, 1'b0, 1'b0, 1'b0, RES_WORD, 32'd0},
		'{KIND_SEED, 64'd0, 25'd0, 1'b0, 1'b0, 1'b0, RES_WORD, 32'd0},
		'{KIND_WORD, 64'hFFFF_FFFF_FFFF_FFFF, 25'h1FFFFFF, 1'b1, 1'b1, 1'b0, RES_WORD, 32'd0},
		'{KIND_SEED, 64'hFFFF_FFFF_FFFF_FFFF, 25'h1FFFFFF, 1'b1, 1'b1, 1'b0, RES_WORD, 32'd0},
		'{KIND_FRAC, 64'hFFFF_FFFF_FFFF_FFFF, 25'h1FFFFFF, 1'b1, 1'b1, 1'b0, RES_WORD, 32'd0},
		'{KIND_WEIGHT, 64'd0, 25'd0, 1'b1, 1'b1, 1'b1, RES_INDEX, 32'd0},
		'{KIND_WEIGHT, 64'd0, 25'h1000000, 1'b1, 1'b0, 1'b1, RES_INDEX, 32'd0},
		'{KIND_WEIGHT, 64'd0, 25'h1FFFFFF, 1'b0, 1'b0, 1'b0, RES_WORD, 32'd0},
		'{KIND_WEIGHT, 64'd0, 25'h1FFFFFF, 1'b0, 1'b1, 1'b0, RES_WORD, 32'd0},
		'{KIND_WEIGHT, 64'd0, 25'd0, 1'b1, 1'b0, 1'b0, RES_WORD, 32'd0},
		'{KIND_WEIGHT, 64'd0, 25'd0, 1'b0, 1'b0, 1'b0, RES_WORD, 32'd0},
		'{KIND_WEIGHT, 64'd0, 25'd0, 1'b0, 1'b1, 1'b0, RES_WORD, 32'd0},
		'{KIND_WEIGHT, 64'd0, 25'h1FFFFFF, 1'b1, 1'b0, 1'b1, RES_INDEX, 32'd0},
		'{KIND_SEED, 64'h0123_4567_89AB_CDEF, 25'd0, 1'b0, 1'b0, 1'b0, RES_WORD, 32'd0},
		'{KIND_WORD, 64'hAAAA_AAAA_AAAA_AAAA, 25'h0AAAAAA, 1'b0, 1'b1, 1'b0, RES_WORD, 32'd0},
		'{KIND_WEIGHT, 64'd0, 25'h0800000, 1'b1, 1'b0, 1'b0, RES_WORD, 32'd0},
		'{KIND_WEIGHT, 64'd0, 25'h0800000, 1'b0, 1'b1, 1'b0, RES_WORD, 32'd0},
		'{KIND_SEED, 64'h8000_0000_0000_0000, 25'd0, 1'b0, 1'b0, 1'b0, RES_WORD, 32'd0},
		'{KIND_WEIGHT, 64'd0, 25'd0, 1'b1, 1'b0, 1'b0, RES_WORD, 32'd0},
		'{KIND_SEED, 64'h5555_5555_5555_5555, 25'h1555555, 1'b0, 1'b0, 1'b0, RES_WORD, 32'd0},
		'{KIND_WEIGHT, 64'd0, 25'd0, 1'b0, 1'b1, 1'b0, RES_WORD, 32'd0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_MULT;
	logic [63:0] cfg_data = 64'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = KIND_SEED;
	logic [63:0] seed_value = 64'd0;
	logic [24:0] weight = 25'd0;
	logic        first_weight = 1'b0;
	logic        last_weight = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  result_kind;
	logic [31:0] value;

	// predictor state
	logic [63:0] gen_st;
	logic [63:0] mul_r;
	logic [63:0] inc_r;
	logic [23:0] thresh_r;
	logic [24:0] acc_sum;
	logic [16:0] elem_idx;
	logic        picked;

	draw_t draws_due[$];

	int  items_sent = 0;
	int  words_checked = 0;
	int  picks_seen = 0;
	int  stalled_offers = 0;
	int  bad_words = 0;
	int  settings_used = 1;
	int  long_dists = 0;
	int  cycle_cnt = 0;
	bit  calm = 1'b0;
	bit  hold_done = 1'b0;

	lcg_random_with_categorical_pick u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.seed_value   (seed_value),
		.weight       (weight),
		.first_weight (first_weight),
		.last_weight  (last_weight),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.value        (value)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [63:0] lcg_next(input logic [63:0] s);
		return s * mul_r + inc_r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic rng_step(input kind_t k, input logic [63:0] sd, input logic [24:0] w,
			input logic f, input logic l, output logic has, output draw_t r);
		logic [25:0] total;
		logic [16:0] idx;
		has = 1'b0;
		r = '0;
		case (k)
			KIND_SEED: begin
				gen_st = sd;
				repeat (WARMUP_STEPS) gen_st = lcg_next(gen_st);
			end
			KIND_WORD: begin
				gen_st = lcg_next(gen_st);
				has = 1'b1;
				r = '{RES_WORD, gen_st[63:32]};
			end
			KIND_FRAC: begin
				gen_st = lcg_next(gen_st);
				has = 1'b1;
				r = '{RES_FRAC, {8'd0, gen_st[63:40]}};
			end
			KIND_WEIGHT: begin
				if (f) begin
					gen_st = lcg_next(gen_st);
					thresh_r = gen_st[63:40];
					acc_sum = '0;
					elem_idx = '0;
					picked = 1'b0;
				end
				idx = elem_idx;
				total = {1'b0, acc_sum} + {1'b0, w};
				if (total > {1'b0, SUM_MAX})
					total = {1'b0, SUM_MAX};
				acc_sum = total[24:0];
				if (elem_idx < 17'(MAX_CHOICES - 1))
					elem_idx = elem_idx + 17'd1;
				if (!picked && (acc_sum >= {1'b0, thresh_r} || l)) begin
					picked = 1'b1;
					has = 1'b1;
					r = '{RES_INDEX, {15'd0, idx}};
				end
			end
		endcase
	endtask

	task automatic offer(input kind_t k, input logic [63:0] sd, input logic [24:0] w,
			input logic f, input logic l, input logic typed, input logic [1:0] rk,
			input logic [31:0] v);
		logic  has;
		draw_t r;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		seed_value <= sd;
		weight <= w;
		first_weight <= f;
		last_weight <= l;
		do @(posedge clk); while (in_stall);
		rng_step(k, sd, w, f, l, has, r);
		if (typed)
			draws_due.push_back('{rk, v});
		else if (has)
			draws_due.push_back(r);
		items_sent++;
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		while (draws_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic load_setting(input logic [63:0] m, input logic [63:0] a);
		cfg_we <= 1'b1;
		cfg_index <= REG_MULT;
		cfg_data <= m;
		@(posedge clk);
		cfg_index <= REG_INCR;
		cfg_data <= a;
		@(posedge clk);
		cfg_we <= 1'b0;
		mul_r = m;
		inc_r = a;
		settings_used++;
	endtask

	task automatic random_part(input int n);
		int          stop_at;
		int          sel;
		int          len;
		logic [24:0] wmax;
		logic [63:0] sd;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			sel = $urandom_range(0, 99);
			if (sel < 6) begin
				case ($urandom_range(0, 3))
					0: sd = 64'd0;
					1: sd = '1;
					default: sd = rand64();
				endcase
				offer(KIND_SEED, sd, 25'($urandom), 1'($urandom), 1'($urandom),
					1'b0, RES_WORD, 32'd0);
			end else if (sel < 26) begin
				offer(KIND_WORD, rand64(), 25'($urandom), 1'($urandom), 1'($urandom),
					1'b0, RES_WORD, 32'd0);
			end else if (sel < 40) begin
				offer(KIND_FRAC, rand64(), 25'($urandom), 1'($urandom), 1'($urandom),
					1'b0, RES_WORD, 32'd0);
			end else if (sel < 88) begin
				// well-formed distribution, now and then missing its last mark or broken by a word draw
				if (long_dists < 2 && $urandom_range(0, 49) == 0) begin
					long_dists++;
					len = $urandom_range(MAX_CHOICES + 1, MAX_CHOICES + 44);
					wmax = 25'd3;
				end else begin
					len = $urandom_range(1, 8);
					wmax = 25'(SUM_MAX / len);
				end
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 9) == 0)
						offer(KIND_WORD, rand64(), 25'($urandom), 1'($urandom),
							1'($urandom), 1'b0, RES_WORD, 32'd0);
					offer(KIND_WEIGHT, rand64(), 25'($urandom_range(0, wmax)), i == 0,
						i == len - 1 && $urandom_range(0, 7) != 0, 1'b0, RES_WORD, 32'd0);
				end
			end else begin
				offer(KIND_WEIGHT, rand64(),
					$urandom_range(0, 3) == 0 ? 25'h1000000 : 25'($urandom),
					1'($urandom), 1'($urandom), 1'b0, RES_WORD, 32'd0);
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin
		draw_t exp_w;
		if (arst_n) begin
			if (in_valid && in_stall)
				stalled_offers++;
			if (out_valid && !out_stall) begin
				if (draws_due.size() == 0) begin
					if (bad_words < 10)
						$display("unexpected word: kind %0d value %h", result_kind, value);
					bad_words++;
				end else begin
					exp_w = draws_due.pop_front();
					words_checked++;
					if (result_kind == RES_INDEX)
						picks_seen++;
					if (result_kind !== exp_w.rk || value !== exp_w.val) begin
						if (bad_words < 10)
							$display("mismatch: expected kind %0d value %h, got kind %0d value %h",
								exp_w.rk, exp_w.val, result_kind, value);
						bad_words++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("tb: failure");
			$finish;
		end
	end

	// receiver stalls, with one long hold-off early in the run
	initial begin
		while (!arst_n) @(posedge clk);
		forever begin
			if (calm) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else if (!hold_done && items_sent >= 200) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
		end
	end

	initial begin
		gen_st = '0;
		mul_r = MULT_RESET;
		inc_r = INCR_RESET;
		thresh_r = '0;
		acc_sum = '0;
		elem_idx = '0;
		picked = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			offer(DIRECTED[i].k, DIRECTED[i].sd, DIRECTED[i].w, DIRECTED[i].f,
				DIRECTED[i].l, DIRECTED[i].typed, DIRECTED[i].rk, DIRECTED[i].val);

		quiesce();
		load_setting('1, '1);
		random_part(300);
		quiesce();
		load_setting(64'd0, 64'd0);
		random_part(150);
		quiesce();
		load_setting(rand64(), rand64());
		random_part(450);
		quiesce();
		load_setting(64'd1, rand64());
		random_part(300);
		quiesce();
		calm = 1'b1;
		load_setting(MULT_RESET, INCR_RESET);
		random_part(600);
		quiesce();

		if (draws_due.size() != 0) begin
			$display("%0d results never arrived", draws_due.size());
			bad_words += draws_due.size();
		end
		$display("%0d input words over %0d generator settings, %0d long distributions",
			items_sent, settings_used, long_dists);
		$display("%0d result words checked (%0d picks), %0d stalled input cycles, %0d errors",
			words_checked, picks_seen, stalled_offers, bad_words);
		if (bad_words == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### filelist.f
+incdir+sv
sv/lcgp_pkg.sv
sv/lcgp_ctrl.sv
sv/lcgp_dp.sv
sv/lcg_random_with_categorical_pick.sv
sim/lcg_random_with_categorical_pick_tb.sv
